[src/mcs_pkg.sv]
// ----------------------------------------------------------------------------
// Maximum clique size package
// Shared widths, default parameter values and the sequencer state type for
// the small-graph maximum clique search block.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // Default number of vertices the search hardware supports.
  localparam int MAX_VERTICES = 7;

  // Width of the packed edge-bit field carried by one input item.
  localparam int EDGE_W = 21;

  // Width of the vertex count register.
  localparam int COUNT_W = 3;

  // Width of the clique size result field.
  localparam int SIZE_W = 3;

  // Reset value of the vertex count register.
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 3'd7;

  // Sequencer states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

[src/mcs_edge_if.sv]
// ----------------------------------------------------------------------------
// Graph input channel
// Valid/ready channel that carries one packed edge-bit vector per item.
// ----------------------------------------------------------------------------
interface mcs_edge_if;
  logic                        valid;
  logic                        ready;
  logic [mcs_pkg::EDGE_W-1:0]  edge_bits;

  modport source (output valid, output edge_bits, input ready);
  modport sink   (input valid, input edge_bits, output ready);
endinterface

[src/mcs_size_if.sv]
// ----------------------------------------------------------------------------
// Clique size output channel
// Valid/ready channel that carries one clique size per item.
// ----------------------------------------------------------------------------
interface mcs_size_if;
  logic                        valid;
  logic                        ready;
  logic [mcs_pkg::SIZE_W-1:0]  clique_size;

  modport source (output valid, output clique_size, input ready);
  modport sink   (input valid, input clique_size, output ready);
endinterface

[src/mcs_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the vertex count register.
// ----------------------------------------------------------------------------
interface mcs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mcs_pkg::COUNT_W-1:0] vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink   (input valid, input vertex_count, output ready);
endinterface

[src/mcs_subset_check.sv]
// ----------------------------------------------------------------------------
// Subset clique checker
// Shared unit that tests one vertex subset per cycle: it flags whether every
// pair of member vertices is joined by an edge and counts the members.
// ----------------------------------------------------------------------------
module mcs_subset_check #(
  parameter int MaxVertices = mcs_pkg::MAX_VERTICES,
  parameter int NumPairs    = MaxVertices * (MaxVertices - 1) / 2,
  parameter int CntW        = $clog2(MaxVertices + 1)
) (
  input  logic [NumPairs-1:0]    edges_i,
  input  logic [MaxVertices-1:0] members_i,
  output logic                   is_clique_o,
  output logic [CntW-1:0]        size_o
);

  logic [NumPairs-1:0] missing;

  // A pair is missing when both vertices are members and the edge is absent.
  for (genvar a = 1; a < MaxVertices; a++) begin : g_hi
    for (genvar b = 0; b < a; b++) begin : g_lo
      localparam int Idx = a * (a - 1) / 2 + b;
      assign missing[Idx] = members_i[a] & members_i[b] & ~edges_i[Idx];
    end
  end

  assign is_clique_o = ~|missing;

  // Population count of the subset.
  always_comb begin
    size_o = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      size_o = size_o + CntW'(members_i[i]);
    end
  end

endmodule

[src/max_clique_size_small_graph.sv]
// ----------------------------------------------------------------------------
// Maximum clique size of a small graph
// Operation: an accepted graph is scanned over all 2^n vertex subsets, n
// the vertex count saturated to MaxVertices; the last subset holds until the
// output register is free. No new graph is taken during a scan. The only
// search resource is the subset checker: one subset per cycle bar that hold.
// Reset: asynchronous, active low; vertex count returns to seven, no result.
// ----------------------------------------------------------------------------
module max_clique_size_small_graph #(
  parameter int MaxVertices = mcs_pkg::MAX_VERTICES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcs_cfg_if.sink     cfg_i,
  mcs_edge_if.sink    graph_i,
  mcs_size_if.source  result_o
);

  localparam int NumPairs = MaxVertices * (MaxVertices - 1) / 2;
  localparam int CntW     = $clog2(MaxVertices + 1);

  mcs_pkg::state_e                 state_q, state_d;
  logic [mcs_pkg::COUNT_W-1:0]     vertex_count_q;
  logic [NumPairs-1:0]             edges_q, edges_d;
  logic [MaxVertices-1:0]          members_q, members_d;
  logic [MaxVertices-1:0]          last_q, last_d;
  logic [CntW-1:0]                 best_q, best_d;
  logic                            out_valid_q, out_valid_d;
  logic [mcs_pkg::SIZE_W-1:0]      out_size_q, out_size_d;
  logic [CntW-1:0]                 nv;
  logic                            is_clique;
  logic [CntW-1:0]                 subset_size;
  logic                            graph_acc;

  // Configuration register; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= mcs_pkg::VERTEX_COUNT_RST;
    end else if (cfg_i.valid) begin
      vertex_count_q <= cfg_i.vertex_count;
    end
  end

  // Saturate the vertex count to the supported maximum.
  always_comb begin
    if (int'(vertex_count_q) > MaxVertices) begin
      nv = CntW'(MaxVertices);
    end else begin
      nv = CntW'(vertex_count_q);
    end
  end

  // Last subset of the scan: the low nv bits set.
  for (genvar i = 0; i < MaxVertices; i++) begin : g_last
    assign last_d[i] = (int'(nv) > i);
  end

  // Edge bits past the carried field read as zero.
  for (genvar k = 0; k < NumPairs; k++) begin : g_edge
    if (k < mcs_pkg::EDGE_W) begin : g_in
      assign edges_d[k] = graph_i.edge_bits[k];
    end else begin : g_zero
      assign edges_d[k] = 1'b0;
    end
  end

  // Shared subset checker.
  mcs_subset_check #(
    .MaxVertices (MaxVertices),
    .NumPairs    (NumPairs),
    .CntW        (CntW)
  ) u_check (
    .edges_i     (edges_q),
    .members_i   (members_q),
    .is_clique_o (is_clique),
    .size_o      (subset_size)
  );

  assign graph_i.ready   = (state_q == mcs_pkg::ST_IDLE);
  assign graph_acc       = graph_i.valid && graph_i.ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.clique_size = out_size_q;

  // Sequencer: walk every subset, keep the largest clique, then publish.
  always_comb begin
    state_d     = state_q;
    members_d   = members_q;
    best_d      = best_q;
    out_valid_d = out_valid_q;
    out_size_d  = out_size_q;

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      mcs_pkg::ST_IDLE: begin
        if (graph_acc) begin
          members_d = '0;
          best_d    = '0;
          state_d   = mcs_pkg::ST_SCAN;
        end
      end
      mcs_pkg::ST_SCAN: begin
        if (is_clique && (subset_size > best_q)) begin
          best_d = subset_size;
        end
        if (members_q == last_q) begin
          // Hold on the last subset until the output register is free.
          if (!out_valid_q || result_o.ready) begin
            out_valid_d = 1'b1;
            out_size_d  = mcs_pkg::SIZE_W'(best_d);
            state_d     = mcs_pkg::ST_IDLE;
          end
        end else begin
          members_d = members_q + MaxVertices'(1);
        end
      end
      default: state_d = mcs_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    members_q  <= members_d;
    best_q     <= best_d;
    out_size_q <= out_size_d;
    if (graph_acc) begin
      edges_q <= edges_d;
      last_q  <= last_d;
    end
  end

  // An accepted graph always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    graph_acc |=> (state_q == mcs_pkg::ST_SCAN) && (members_q == '0))
    else $error("scan did not start after graph accept");

  // The scan never walks past the last subset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcs_pkg::ST_SCAN) |-> ((members_q & ~last_q) == '0))
    else $error("subset outside the vertex range");

  // The best size only grows during a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcs_pkg::ST_SCAN) |=> (best_q >= $past(best_q)))
    else $error("best clique size decreased");

  // A new result appears only at the end of a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == mcs_pkg::ST_SCAN)
                           && (state_q == mcs_pkg::ST_IDLE))
    else $error("result published outside scan end");

endmodule
